### src/kvt_pkg.sv
package kvt_pkg;

  // Table geometry.
  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Fixed field widths on the ports.
  localparam int CMD_W       = 2;
  localparam int KEY_FIELD_W = 64;
  localparam int VALUE_W     = 64;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 4;
  localparam int CAP_W       = 5;

  // Width for comparing a slot number against the capacity register.
  localparam int CMP_W = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_ASK    = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_t;

  // Search result as it moves from cell to cell.
  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [VALUE_W-1:0] hit_value;
    logic               free;
    logic [IDX_W-1:0]   free_idx;
  } scan_t;

  // Update broadcast to the cells at the end of a request.
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } slot_wr_t;

  // Low bits of a slot number, zero extended when the table is small.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

### src/kvt_req_if.sv
interface kvt_req_if
  import kvt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [KEY_FIELD_W-1:0] lookup_key;
  logic [VALUE_W-1:0]     store_value;

  modport source (output valid, output command, output lookup_key, output store_value,
                  input ready);
  modport sink   (input valid, input command, input lookup_key, input store_value,
                  output ready);
endinterface

### src/kvt_rsp_if.sv
interface kvt_rsp_if
  import kvt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  found_value;
  logic [SLOT_W-1:0]   slot_index;

  modport source (output valid, output status, output found_value, output slot_index,
                  input ready);
  modport sink   (input valid, input status, input found_value, input slot_index,
                  output ready);
endinterface

### src/kvt_cell.sv
// One table slot. It merges its own match and free status into the search
// result from its left neighbor and registers the result for its right one.
module kvt_cell
  import kvt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [IDX_W-1:0]    idx,
  input  logic [KEY_BITS-1:0] key,
  input  logic [VALUE_W-1:0]  value,
  input  logic [CAP_W-1:0]    cap,
  input  slot_wr_t            wr,
  input  scan_t               scan_in,
  output scan_t               scan_out
);

  logic                valid;
  logic [KEY_BITS-1:0] slot_key;
  logic [VALUE_W-1:0]  slot_value;
  logic                sel;
  logic                match;
  logic                usable;
  scan_t               scan_next;

  assign sel    = (wr.idx == idx);
  assign match  = valid && (slot_key == key);
  assign usable = !valid && (CMP_W'(idx) < CMP_W'(cap));

  always_comb begin
    scan_next = scan_in;
    if (!scan_in.hit && match) begin
      scan_next.hit       = 1'b1;
      scan_next.hit_idx   = idx;
      scan_next.hit_value = slot_value;
    end
    if (!scan_in.free && usable) begin
      scan_next.free     = 1'b1;
      scan_next.free_idx = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel && wr.set) begin
      valid <= 1'b1;
    end else if (sel && wr.clr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.set) begin
      slot_key   <= key;
      slot_value <= value;
    end
    scan_out <= scan_next;
  end

endmodule

### src/key_value_table.sv
// Channel   Direction  Payload                                   Role
// req       in         command, lookup_key, store_value          add, remove or ask
// rsp       out        status, found_value, slot_index           one result per request
// cfg       in         cfg_we, cfg_data                          capacity_in_use register
//
// After acceptance the search walks the row of cells slot by slot in the scan state; the resolve
// state then settles the result and updates a slot, and the table returns to idle, where the next
// request is taken. No request is taken while another is in progress. The result is offered from
// the output register once the resolve state has loaded it.
// Reset (rst, synchronous) clears every slot valid bit and sets the capacity to 16. While rsp
// is stalled the next request is still taken, but its resolve cycle waits for an empty output.
module key_value_table
  import kvt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  kvt_req_if.sink          req,
  kvt_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  // Control state.
  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] cnt;
  logic [CAP_W-1:0] cap;

  // The request being worked on. It is held for the whole search, so every
  // cell sees the same key while the search result ripples through the row.
  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [VALUE_W-1:0]  value_q;

  // Output register.
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_value;
  logic [SLOT_W-1:0]   out_slot;

  // Result of the resolve cycle.
  logic                load;
  logic                out_free;
  status_t             res_status;
  logic [VALUE_W-1:0]  res_value;
  logic [SLOT_W-1:0]   res_slot;
  slot_wr_t            wr;

  // The search chain. Link 0 feeds the first cell with an empty result and
  // the last link carries the answer for the whole table.
  scan_t chain [ENTRIES+1];
  scan_t scan_last;

  assign chain[0]  = '0;
  assign scan_last = chain[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(i)),
      .key      (key_q),
      .value    (value_q),
      .cap      (cap),
      .wr       (wr),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  // Next state, and the decision made once the search has passed every cell.
  always_comb begin
    state_next = state;
    load       = 1'b0;
    res_status = ST_OK;
    res_value  = '0;
    res_slot   = '0;
    wr         = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt == IDX_W'(ENTRIES - 1)) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
          case (cmd_q)
            CMD_ADD: begin
              // A key present anywhere blocks the add, even past the capacity.
              if (scan_last.hit) begin
                res_status = ST_PRESENT;
              end else if (scan_last.free) begin
                wr.set   = 1'b1;
                wr.idx   = scan_last.free_idx;
                res_slot = to_slot(scan_last.free_idx);
              end else begin
                res_status = ST_FULL;
              end
            end
            CMD_REMOVE: begin
              if (scan_last.hit) begin
                wr.clr   = 1'b1;
                wr.idx   = scan_last.hit_idx;
                res_slot = to_slot(scan_last.hit_idx);
              end else begin
                res_status = ST_NOT_FOUND;
              end
            end
            CMD_ASK: begin
              if (scan_last.hit) begin
                res_value = scan_last.hit_value;
                res_slot  = to_slot(scan_last.hit_idx);
              end else begin
                res_status = ST_NOT_FOUND;
              end
            end
            default: begin
              // The unused command code leaves the table alone and reports ok.
              res_status = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        cnt <= cnt + IDX_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  // Only the low KEY_BITS bits of the key take part in the table.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q   <= req.command;
      key_q   <= req.lookup_key[KEY_BITS-1:0];
      value_q <= req.store_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_slot   <= res_slot;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_value = out_value;
  assign rsp.slot_index  = out_slot;

  // One request at a time: acceptance closes the input until it resolves.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in progress");

  // A stored key never duplicates one already in the table.
  a_no_duplicate: assert property (@(posedge clk) disable iff (rst)
    wr.set |-> !scan_last.hit)
    else $error("add stores a key that is already present");

  // Table full is reported only when the search found no usable slot.
  a_full_honest: assert property (@(posedge clk) disable iff (rst)
    (load && res_status == ST_FULL) |-> !scan_last.free)
    else $error("table full reported with a free slot in range");

  // A result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(out_status) && $stable(out_slot)))
    else $error("pending result lost or changed");

endmodule
